@@ src/mfc_pkg.sv @@
// types and constants shared by the matched filter correlator
package mfc_pkg;

    // sample and tap width, fixed by the payload fields
    localparam int SAMPLE_BITS = 16;
    // accumulator and result sum width
    localparam int SUM_W = 40;
    // result index width
    localparam int INDEX_W = 10;
    // tap index field width
    localparam int TAP_INDEX_W = 7;
    // configuration port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    // register widths
    localparam int TAP_COUNT_W = 8;
    localparam int OUT_COUNT_W = 11;
    // reset value of both count registers
    localparam int DEFAULT_COUNT = 100;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [TAP_INDEX_W-1:0]        tap_index;
        logic signed [SAMPLE_BITS-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] correlation_sum;
        logic [INDEX_W-1:0]      output_index;
        logic                    last_output;
    } res_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic last;
    } mac_ctrl_t;

endpackage

@@ src/matched_filter_correlator.sv @@
// matched filter correlator top level: sequencer, stores and result register
//
// Requests arrive on req (valid/ready). A load request writes one template
// tap, a restart request clears the window fill, window head and output
// count, and a sample request shifts one sample into a sliding window. Once
// tap_count samples are held, each sample yields one correlation result on
// res (valid/ready), until output_count results have been given.
// Load, restart and idle-mode requests leave the sequencer idle. A sample
// that yields a result uses M taps, M being the taps in use (at most
// MAX_TAPS): one shared multiply-accumulate walks the taps, one per cycle,
// fed by the registered read ports of the template and window memories, with
// a product register and accumulator behind them. req_ready is low meanwhile.
// The result register lets the next request be taken while a result waits;
// if the receiver still stalls when the next sum is ready, the sequencer
// holds it until the register frees. The configuration port (cfg) is always
// ready and is meant to be written while the block is idle.
// Reset clears all control state and sets both counts to 100. The memories
// are not cleared; taps must be loaded before use.
module matched_filter_correlator import mfc_pkg::*; #(
    parameter int MAX_TAPS    = 128,
    parameter int MAX_OUTPUTS = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  req_t                   req,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_t                   res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int DW = $clog2(MAX_OUTPUTS + 1);
    localparam int PW = AW + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic [OUT_COUNT_W-1:0] output_count_reg;
    logic [TW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [DW-1:0]          done_reg, done_next;
    logic [TW-1:0]          cnt_reg, cnt_next;
    logic [TW-1:0]          m_reg, m_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic                   rd_v_reg, rd_last_reg;
    logic                   res_valid_reg, res_valid_next;
    res_t                   res_reg;

    logic                   accept;
    logic                   is_sample;
    logic [AW-1:0]          head_inc;
    logic [TW-1:0]          fill_inc;
    logic [TW-1:0]          taps_use;
    logic [DW-1:0]          wanted;
    logic [PW-1:0]          start_sum;
    logic [AW-1:0]          start_pos;
    logic                   go;
    logic                   issue_last;
    logic                   load_res;
    logic                   tmpl_we;
    logic [SAMPLE_BITS-1:0] tmpl_rdata;
    logic [SAMPLE_BITS-1:0] win_rdata;
    logic signed [SUM_W-1:0] mac_acc;
    logic                   mac_done;
    mac_ctrl_t              mac_ctrl;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = req_valid && req_ready;
    assign is_sample = accept && (req.mode == MODE_SAMPLE);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg    <= TAP_COUNT_W'(DEFAULT_COUNT);
            output_count_reg <= OUT_COUNT_W'(DEFAULT_COUNT);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TAP_COUNT:    tap_count_reg    <= cfg_data[TAP_COUNT_W-1:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[OUT_COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // taps in use and outputs wanted, clamped to the parameters
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_use = TW'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            taps_use = TW'(MAX_TAPS);
        end
        else
        begin
            taps_use = TW'(tap_count_reg);
        end
        if (32'(output_count_reg) > MAX_OUTPUTS)
        begin
            wanted = DW'(MAX_OUTPUTS);
        end
        else
        begin
            wanted = DW'(output_count_reg);
        end
    end

    // window pointer arithmetic for a new sample
    assign head_inc  = (head_reg == AW'(MAX_TAPS - 1)) ? '0 : head_reg + AW'(1);
    assign fill_inc  = (fill_reg < TW'(MAX_TAPS)) ? fill_reg + TW'(1) : fill_reg;
    assign start_sum = PW'(head_inc) + PW'(MAX_TAPS) - PW'(taps_use);
    assign start_pos = (start_sum >= PW'(MAX_TAPS)) ? AW'(start_sum - PW'(MAX_TAPS))
                                                    : AW'(start_sum);
    assign go        = is_sample && (fill_inc >= taps_use) && (done_reg < wanted);
    assign issue_last = (state_reg == S_RUN) && (cnt_reg == m_reg - TW'(1));
    assign load_res  = ((state_reg == S_WAIT && mac_done) || state_reg == S_HOLD)
                       && (!res_valid_reg || res_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        head_next  = head_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        pos_next   = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.mode == MODE_RESTART)
                begin
                    fill_next = '0;
                    head_next = '0;
                    done_next = '0;
                end
                else if (is_sample)
                begin
                    fill_next = fill_inc;
                    head_next = head_inc;
                    if (go)
                    begin
                        state_next = S_RUN;
                        cnt_next   = '0;
                        m_next     = taps_use;
                        pos_next   = start_pos;
                    end
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + TW'(1);
                pos_next = (pos_reg == AW'(MAX_TAPS - 1)) ? '0 : pos_reg + AW'(1);
                if (issue_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = load_res ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (load_res)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (load_res)
        begin
            done_next = done_reg + DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            head_reg    <= '0;
            done_reg    <= '0;
            cnt_reg     <= '0;
            m_reg       <= TW'(1);
            pos_reg     <= '0;
            rd_v_reg    <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            m_reg       <= m_next;
            pos_reg     <= pos_next;
            rd_v_reg    <= (state_reg == S_RUN);
            rd_last_reg <= issue_last;
        end
    end

    // template and window stores
    assign tmpl_we = accept && (req.mode == MODE_LOAD) && (32'(req.tap_index) < MAX_TAPS);

    mfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_template (
        .clk   (clk),
        .we    (tmpl_we),
        .waddr (AW'(req.tap_index)),
        .wdata (req.data_value),
        .re    (state_reg == S_RUN),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (tmpl_rdata)
    );

    mfc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_window (
        .clk   (clk),
        .we    (is_sample),
        .waddr (head_reg),
        .wdata (req.data_value),
        .re    (state_reg == S_RUN),
        .raddr (pos_reg),
        .rdata (win_rdata)
    );

    // shared multiply-accumulate
    assign mac_ctrl.clear  = go;
    assign mac_ctrl.mul_en = rd_v_reg;
    assign mac_ctrl.last   = rd_last_reg;

    mfc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .tap    ($signed(tmpl_rdata)),
        .sample ($signed(win_rdata)),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg.correlation_sum <= mac_acc;
            res_reg.output_index    <= INDEX_W'(done_reg);
            res_reg.last_output     <= (done_reg + DW'(1) == wanted);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // the accumulator finishes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_WAIT))
        else $error("accumulator finished outside the wait state");

    // the tap counter stays below the captured tap count while running
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (cnt_reg < m_reg))
        else $error("tap counter ran past the tap count");

    // each loaded result advances the output count by one
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> (done_reg == $past(done_reg) + DW'(1)))
        else $error("output count did not advance with a result");

endmodule

@@ src/mfc_ram.sv @@
// single port write, single port read memory with registered read data
module mfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/mfc_mac.sv @@
// shared multiply-accumulate unit with a registered product
module mfc_mac import mfc_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mac_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_BITS-1:0] tap,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SUM_W-1:0]       acc,
    output logic                          done
);

    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic                            prod_v_reg;
    logic                            prod_last_reg;
    logic signed [SUM_W-1:0]         acc_reg;
    logic                            done_reg;

    // product stage
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= tap * sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg    <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_v_reg    <= ctrl.mul_en;
            prod_last_reg <= ctrl.mul_en && ctrl.last;
            done_reg      <= prod_v_reg && prod_last_reg;
        end
    end

    // accumulate, wrapping at the sum width
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

@@ test/matched_filter_correlator_tb.sv @@
// self-checking testbench for the matched filter correlator
module matched_filter_correlator_tb import mfc_pkg::*;;

    localparam int MAX_TAPS     = 128;
    localparam int MAX_OUTPUTS  = 1024;
    // mode with no defined meaning, the block must ignore it
    localparam logic [1:0] MODE_IGNORED = 2'd3;
    // register index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    // covers the longest sample pass over MAX_TAPS taps, with margin
    localparam int SETTLE_CYCLES = MAX_TAPS + 16;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int REPORT_LIMIT  = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    res_t                   res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic signed [SAMPLE_BITS-1:0] tmpl_taps [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] window_samples [MAX_TAPS];
    int unsigned                   window_fill = 0;
    int unsigned                   window_head = 0;
    int unsigned                   outputs_done = 0;
    logic [TAP_COUNT_W-1:0]        tap_count_reg = TAP_COUNT_W'(DEFAULT_COUNT);
    logic [OUT_COUNT_W-1:0]        out_count_reg = OUT_COUNT_W'(DEFAULT_COUNT);

    // correlation results still to come, oldest first
    res_t awaited_corr [$];
    int   mismatch_count = 0;
    int   cycle_count = 0;

    // idling rates in percent
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off, requested by the tests and counted by the receiver
    int unsigned hold_off_len = 0;
    int unsigned hold_off_seq = 0;
    int unsigned hold_seen_seq = 0;
    int unsigned hold_left = 0;

    matched_filter_correlator #(
        .MAX_TAPS    (MAX_TAPS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // update the predicted state for one request, return 1 with the result it yields
    function automatic bit correlate_request(input req_t item, output res_t result);
        int unsigned taps;
        int unsigned wanted;
        int unsigned pos;
        int unsigned i;
        longint      acc;
        result = '0;
        case (item.mode)
            MODE_LOAD:
            begin
                tmpl_taps[item.tap_index] = item.data_value;
                return 1'b0;
            end
            MODE_RESTART:
            begin
                window_fill = 0;
                window_head = 0;
                outputs_done = 0;
                return 1'b0;
            end
            MODE_SAMPLE: ;
            default: return 1'b0;
        endcase

        // shift the sample into the window
        window_samples[window_head] = item.data_value;
        window_head = (window_head + 1) % MAX_TAPS;
        if (window_fill < MAX_TAPS)
            window_fill++;

        // zero taps act as one, anything above the store size as the store size
        if (tap_count_reg == 0)
            taps = 1;
        else if (tap_count_reg > MAX_TAPS)
            taps = MAX_TAPS;
        else
            taps = tap_count_reg;
        wanted = (out_count_reg > MAX_OUTPUTS) ? MAX_OUTPUTS : out_count_reg;
        if (window_fill < taps || outputs_done >= wanted)
            return 1'b0;

        // oldest sample of the window meets tap zero
        pos = (window_head + MAX_TAPS - taps) % MAX_TAPS;
        acc = 0;
        for (i = 0; i < taps; i++)
        begin
            acc += longint'(tmpl_taps[i]) * longint'(window_samples[pos]);
            pos = (pos + 1) % MAX_TAPS;
        end
        result.correlation_sum = acc[SUM_W-1:0];
        result.output_index = outputs_done[INDEX_W-1:0];
        result.last_output = (outputs_done + 1 == wanted);
        outputs_done++;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input res_t want, input res_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch (%s): expected sum %0d index %0d last %0b, ",
                      "got sum %0d index %0d last %0b"},
                     what, want.correlation_sum, want.output_index, want.last_output,
                     got.correlation_sum, got.output_index, got.last_output);
    endtask

    // result checker, receiver stalls and run limit
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (awaited_corr.size() == 0)
                note_mismatch("result with none awaited", '0, res);
            else
            begin
                want = awaited_corr.pop_front();
                if (res.correlation_sum !== want.correlation_sum
                    || res.output_index !== want.output_index
                    || res.last_output !== want.last_output)
                    note_mismatch("field", want, res);
            end
        end

        if (hold_off_seq != hold_seen_seq)
        begin
            hold_seen_seq = hold_off_seq;
            hold_left = hold_off_len;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(99) >= recv_stall_pct);

        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // offer one request, with random idle cycles first, and predict it on acceptance
    task automatic send_req(input logic [1:0] mode, input logic [TAP_INDEX_W-1:0] idx,
                            input logic [SAMPLE_BITS-1:0] value);
        req_t item;
        res_t expected;
        item.mode = mode;
        item.tap_index = idx;
        item.data_value = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (correlate_request(item, expected))
            awaited_corr.push_back(expected);
    endtask

    // stop sending, wait for every awaited result, then let the block go quiet
    task automatic settle_block();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_corr.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_TAP_COUNT:    tap_count_reg = data[TAP_COUNT_W-1:0];
            REG_OUTPUT_COUNT: out_count_reg = data[OUT_COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // write both counts while idle; upper data bits carry junk
    task automatic program_counts(input int unsigned taps, input int unsigned outs,
                                  input bit touch_unused);
        logic [CFG_DATA_W-1:0] junk;
        settle_block();
        junk = CFG_DATA_W'($urandom);
        if (touch_unused)
            write_reg(REG_UNUSED, junk);
        write_reg(REG_TAP_COUNT, {junk[CFG_DATA_W-1:TAP_COUNT_W], taps[TAP_COUNT_W-1:0]});
        write_reg(REG_OUTPUT_COUNT, {junk[CFG_DATA_W-1:OUT_COUNT_W], outs[OUT_COUNT_W-1:0]});
        cfg_valid <= 1'b0;
    endtask

    // full-scale taps and samples at the reset counts, then the largest tap count
    task automatic test_extreme_sums();
        int i;
        send_idle_pct = 35;
        recv_stall_pct = 35;
        for (i = 0; i < MAX_TAPS; i++)
            send_req(MODE_LOAD, i[TAP_INDEX_W-1:0], 16'h8000);
        repeat (DEFAULT_COUNT) send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h8000);
        // tap count above the store size, window keeps filling to the full store
        program_counts(255, 2, 1'b0);
        repeat (MAX_TAPS - DEFAULT_COUNT)
            send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h8000);
        // all outputs done, sample still shifts in
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h7fff);
        send_req(MODE_RESTART, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
    endtask

    // random template over the whole store
    task automatic test_load_template();
        int i;
        send_idle_pct = 69;
        recv_stall_pct = 0;
        for (i = 0; i < MAX_TAPS; i++)
            send_req(MODE_LOAD, i[TAP_INDEX_W-1:0], SAMPLE_BITS'($urandom));
    endtask

    // ignored mode, output limit, restart, zero counts, changes mid-stream
    task automatic test_special_cases();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        program_counts(2, 3, 1'b1);
        send_req(MODE_LOAD, 7'd0, 16'h7fff);
        send_req(MODE_LOAD, 7'd1, 16'h8000);
        send_req(MODE_IGNORED, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        send_req(MODE_RESTART, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h7fff);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h8000);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h0000);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'hffff);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h0005);
        // restart keeps template and window contents
        send_req(MODE_RESTART, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h0001);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), 16'h0002);
        // zero taps act as one, zero outputs gives nothing
        program_counts(0, 0, 1'b0);
        repeat (3) send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        // new counts without a restart apply from the next sample
        program_counts(4, 5, 1'b0);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        send_req(MODE_LOAD, 7'd3, 16'h04d2);
        send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
    endtask

    // output count above the limit, every output index once, single tap
    task automatic test_full_output_range();
        send_idle_pct = 35;
        recv_stall_pct = 69;
        program_counts(0, 2047, 1'b0);
        send_req(MODE_RESTART, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        repeat (MAX_OUTPUTS + 2)
            send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
    endtask

    // mostly samples, some loads and restarts, a few ignored requests
    task automatic run_random_requests(input int count);
        int          n;
        int unsigned pick;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
            else if (pick < 88)
                send_req(MODE_LOAD, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
            else if (pick < 96)
                send_req(MODE_RESTART, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
            else
                send_req(MODE_IGNORED, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        end
    endtask

    // small counts mostly, now and then the extremes
    task automatic program_random_counts();
        int unsigned taps;
        int unsigned outs;
        if ($urandom_range(9) != 0)
            taps = $urandom_range(1, 12);
        else
            case ($urandom_range(3))
                0: taps = 0;
                1: taps = MAX_TAPS;
                2: taps = 255;
                default: taps = $urandom_range(13, 127);
            endcase
        if ($urandom_range(3) != 0)
            outs = $urandom_range(1, 30);
        else
            case ($urandom_range(3))
                0: outs = 0;
                1: outs = MAX_OUTPUTS;
                2: outs = 2047;
                default: outs = $urandom_range(31, 1023);
            endcase
        program_counts(taps, outs, 1'b0);
    endtask

    // random traffic under each idling pattern
    task automatic test_random_phases();
        int unsigned send_pcts [4] = '{0, 69, 0, 35};
        int unsigned recv_pcts [4] = '{0, 0, 69, 35};
        int          p;
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            repeat (2)
            begin
                program_random_counts();
                run_random_requests(60);
            end
        end
    endtask

    // receiver holds off long enough to back up the block, then the sender pauses
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_counts(3, 200, 1'b0);
        send_req(MODE_RESTART, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        hold_off_len = 400;
        hold_off_seq++;
        repeat (40) send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
        settle_block();
        recv_stall_pct = 35;
        repeat (30) send_req(MODE_SAMPLE, TAP_INDEX_W'($urandom), SAMPLE_BITS'($urandom));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_sums();
        test_load_template();
        test_special_cases();
        test_full_output_range();
        test_random_phases();
        test_backpressure();

        settle_block();
        mismatch_count += awaited_corr.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
